// ===== rtl/sm3_pkg.sv =====
// SM3 package: shared types, constants and round helpers.
// No dependencies.
package sm3_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned MsgWords = 16;

  localparam logic [31:0] T_LO = 32'h79CC4519;
  localparam logic [31:0] T_HI = 32'h7A879D8A;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [255:0] IV = {
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  typedef enum logic [0:0] {
    OP_ABSORB = 1'b0,
    OP_FINISH = 1'b1
  } op_t;

  // Queue entry: a byte to store, with markers for block end and digest request.
  typedef struct packed {
    logic [7:0] data;
    logic       blk_end;   // byte completes a block: compress after it
    logic       emit;      // after compress, emit the digest and reset
  } qent_t;

  typedef enum logic [1:0] {
    B_FILL = 2'd0,
    B_COMP = 2'd1,
    B_EMIT = 2'd2
  } bstate_t;

  typedef enum logic [1:0] {
    F_IDLE = 2'd0,
    F_PAD  = 2'd1,
    F_LEN  = 2'd2
  } fstate_t;

  function automatic logic [31:0] rol(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rol(x, 5'd9) ^ rol(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rol(x, 5'd15) ^ rol(x, 5'd23);
  endfunction

endpackage

// ===== rtl/sm3_if.sv =====
// Valid/ready channel interfaces for the SM3 block.
// Depends on nothing.
interface sm3_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;
  modport source (output valid, operation, data_byte, input ready);
  modport sink (input valid, operation, data_byte, output ready);
endinterface

interface sm3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        word_last;
  modport source (output valid, digest_word, word_last, input ready);
  modport sink (input valid, digest_word, word_last, output ready);
endinterface

// ===== rtl/sm3_front.sv =====
// SM3 front end: takes transactions, generates padding bytes and length.
// Depends on sm3_pkg.
module sm3_front import sm3_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_operation,
  input  logic [7:0] in_data_byte,
  output logic       q_valid,
  input  logic       q_ready,
  output qent_t      q_data
);

  fstate_t     st_r, st_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic [2:0]  lidx_r, lidx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= F_IDLE;
      fill_r <= '0;
      bits_r <= '0;
      lidx_r <= '0;
    end else begin
      st_r   <= st_nxt;
      fill_r <= fill_nxt;
      bits_r <= bits_nxt;
      lidx_r <= lidx_nxt;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    fill_nxt = fill_r;
    bits_nxt = bits_r;
    lidx_nxt = lidx_r;
    in_ready = 1'b0;
    q_valid  = 1'b0;
    q_data   = '0;
    case (st_r)
      F_IDLE: begin
        in_ready = q_ready;
        q_valid  = in_valid;
        if (op_t'(in_operation) == OP_ABSORB) begin
          q_data.data    = in_data_byte;
          q_data.blk_end = (fill_r == 6'd63);
        end else begin
          q_data.data    = PAD_BYTE;
          q_data.blk_end = (fill_r == 6'd63);
        end
        if (in_valid && q_ready) begin
          fill_nxt = fill_r + 6'd1;
          bits_nxt = bits_r + 64'd8;
          if (op_t'(in_operation) == OP_FINISH) begin
            bits_nxt = bits_r;
            st_nxt   = (fill_r == 6'd55) ? F_LEN : F_PAD;
            lidx_nxt = '0;
          end
        end
      end
      F_PAD: begin
        q_valid        = 1'b1;
        q_data.data    = 8'h00;
        q_data.blk_end = (fill_r == 6'd63);
        if (q_ready) begin
          fill_nxt = fill_r + 6'd1;
          if (fill_r == 6'd55) st_nxt = F_LEN;
        end
      end
      F_LEN: begin
        q_valid        = 1'b1;
        q_data.data    = bits_r[8*(7-lidx_r) +: 8];
        q_data.blk_end = (lidx_r == 3'd7);
        q_data.emit    = (lidx_r == 3'd7);
        if (q_ready) begin
          lidx_nxt = lidx_r + 3'd1;
          if (lidx_r == 3'd7) begin
            st_nxt   = F_IDLE;
            fill_nxt = '0;
            bits_nxt = '0;
          end
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

endmodule

// ===== rtl/sm3_queue.sv =====
// Small FIFO between the SM3 front and back ends.
// Depends on sm3_pkg.
module sm3_queue import sm3_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  qent_t wr_data,
  output logic  rd_valid,
  input  logic  rd_ready,
  output qent_t rd_data
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  qent_t mem_r [DEPTH];
  logic [AW:0]   cnt_r, cnt_nxt;
  logic [AW-1:0] wp_r, rp_r;
  logic wr_go, rd_go;

  assign wr_ready = (cnt_r != (AW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign wr_go    = wr_valid && wr_ready;
  assign rd_go    = rd_valid && rd_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_go && !rd_go) cnt_nxt = cnt_r + 1'b1;
    if (rd_go && !wr_go) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= '0;
      rp_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr_go) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (rd_go) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_go) mem_r[wp_r] <= wr_data;
  end

endmodule

// ===== rtl/sm3_back.sv =====
// SM3 back end: block word buffer, message expansion window, 64 rounds,
// chaining value and digest output. Depends on sm3_pkg.
module sm3_back import sm3_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  qent_t       q_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic        out_word_last
);

  bstate_t     st_r, st_nxt;
  logic [31:0] w_r [MsgWords];      // sliding window w[j..j+15]
  logic [31:0] w_nxt [MsgWords];
  logic [1:0]  bpos_r, bpos_nxt;
  logic [23:0] part_r, part_nxt;
  logic [3:0]  widx_r, widx_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic        emit_r, emit_nxt;
  logic [2:0]  oidx_r, oidx_nxt;
  logic [255:0] cv_r, cv_nxt;
  logic [31:0] a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [31:0] a_n, b_n, c_n, d_n, e_n, f_n, g_n, h_n;
  logic [31:0] wnew, tj, a12, ss1, ss2, ff, gg, tt1, tt2;
  logic        load_abcd;

  // Round j uses w_r[0] (w[j]) and w_r[4] (w[j+4]); shift adds w[j+16].
  always_comb begin
    wnew = p1(w_r[0] ^ w_r[7] ^ rol(w_r[13], 5'd15)) ^ rol(w_r[3], 5'd7) ^ w_r[10];
    tj   = (rnd_r < 6'd16) ? T_LO : T_HI;
    a12  = rol(a_r, 5'd12);
    ss1  = rol(a12 + e_r + rol(tj, rnd_r[4:0]), 5'd7);
    ss2  = ss1 ^ a12;
    if (rnd_r < 6'd16) begin
      ff = a_r ^ b_r ^ c_r;
      gg = e_r ^ f_r ^ g_r;
    end else begin
      ff = (a_r & b_r) | (a_r & c_r) | (b_r & c_r);
      gg = (e_r & f_r) | (~e_r & g_r);
    end
    tt1 = ff + d_r + ss2 + (w_r[0] ^ w_r[4]);
    tt2 = gg + h_r + ss1 + w_r[0];
  end

  always_comb begin
    st_nxt = st_r;
    bpos_nxt = bpos_r; part_nxt = part_r; widx_nxt = widx_r;
    rnd_nxt = rnd_r; emit_nxt = emit_r; oidx_nxt = oidx_r; cv_nxt = cv_r;
    for (int i = 0; i < MsgWords; i++) w_nxt[i] = w_r[i];
    a_n = a_r; b_n = b_r; c_n = c_r; d_n = d_r;
    e_n = e_r; f_n = f_r; g_n = g_r; h_n = h_r;
    load_abcd = 1'b0;
    q_ready = 1'b0;
    out_valid = 1'b0;
    out_digest_word = cv_r[32*(7-oidx_r) +: 32];
    out_word_last = (oidx_r == 3'd7);
    case (st_r)
      B_FILL: begin
        q_ready = 1'b1;
        if (q_valid) begin
          bpos_nxt = bpos_r + 2'd1;
          if (bpos_r == 2'd3) begin
            w_nxt[widx_r] = {part_r, q_data.data};
            widx_nxt = widx_r + 4'd1;
          end else begin
            part_nxt = {part_r[15:0], q_data.data};
          end
          if (q_data.blk_end) begin
            st_nxt = B_COMP;
            rnd_nxt = '0;
            emit_nxt = q_data.emit;
            load_abcd = 1'b1;
          end
        end
      end
      B_COMP: begin
        for (int i = 0; i < MsgWords - 1; i++) w_nxt[i] = w_r[i+1];
        w_nxt[MsgWords-1] = wnew;
        d_n = c_r; c_n = rol(b_r, 5'd9); b_n = a_r; a_n = tt1;
        h_n = g_r; g_n = rol(f_r, 5'd19); f_n = e_r; e_n = p0(tt2);
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          cv_nxt = cv_r ^ {tt1, a_r, rol(b_r, 5'd9), c_r, p0(tt2), e_r,
                           rol(f_r, 5'd19), g_r};
          widx_nxt = '0;
          oidx_nxt = '0;
          st_nxt = emit_r ? B_EMIT : B_FILL;
        end
      end
      B_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            cv_nxt = IV;
            st_nxt = B_FILL;
          end
        end
      end
      default: st_nxt = B_FILL;
    endcase
    if (load_abcd) begin
      {a_n, b_n, c_n, d_n, e_n, f_n, g_n, h_n} = cv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_FILL;
      bpos_r <= '0;
      widx_r <= '0;
      rnd_r <= '0;
      emit_r <= 1'b0;
      oidx_r <= '0;
      cv_r <= IV;
    end else begin
      st_r <= st_nxt;
      bpos_r <= bpos_nxt;
      widx_r <= widx_nxt;
      rnd_r <= rnd_nxt;
      emit_r <= emit_nxt;
      oidx_r <= oidx_nxt;
      cv_r <= cv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    part_r <= part_nxt;
    for (int i = 0; i < MsgWords; i++) w_r[i] <= w_nxt[i];
    a_r <= a_n; b_r <= b_n; c_r <= c_n; d_r <= d_n;
    e_r <= e_n; f_r <= f_n; g_r <= g_n; h_r <= h_n;
  end

endmodule

// ===== rtl/sm3_hash.sv =====
// SM3 hash top level: front end, byte queue and compression back end.
// Depends on sm3_pkg, sm3_if, sm3_front, sm3_queue, sm3_back.
//
// Absorb transactions append one byte; a finish transaction pads the message
// and returns eight digest words, word 0 first, word_last on the eighth, then
// the block returns to the initial vector. Each completed 64-byte block holds
// the back end for its 64 rounds (one round per cycle on the shared round
// unit), during which the queue of QUEUE_DEPTH entries keeps taking bytes
// until full. Finish expands into padding bytes generated at one per cycle
// while the queue has room (up to 72 bytes when a second block is needed),
// then one compression per block, then eight output transactions.
module sm3_hash import sm3_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input logic clk,
  input logic rst_n,
  sm3_in_if.sink    in_ch,
  sm3_out_if.source out_ch
);

  logic  qi_valid, qi_ready, qo_valid, qo_ready;
  qent_t qi_data, qo_data;

  sm3_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_operation(in_ch.operation), .in_data_byte(in_ch.data_byte),
    .q_valid(qi_valid), .q_ready(qi_ready), .q_data(qi_data)
  );

  sm3_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n,
    .wr_valid(qi_valid), .wr_ready(qi_ready), .wr_data(qi_data),
    .rd_valid(qo_valid), .rd_ready(qo_ready), .rd_data(qo_data)
  );

  sm3_back u_back (
    .clk, .rst_n,
    .q_valid(qo_valid), .q_ready(qo_ready), .q_data(qo_data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_digest_word(out_ch.digest_word), .out_word_last(out_ch.word_last)
  );

endmodule

// ===== rtl/sm3_hash_chk.sv =====
// Port-level checker for sm3_hash and its bind.
// Depends on sm3_hash ports only.
module sm3_hash_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic        out_word_last
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word))
    else $error("output changed while stalled");
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_word_last |=> !out_valid)
    else $error("output continued after last word");
  a_no_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind sm3_hash sm3_hash_chk u_chk (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_digest_word(out_ch.digest_word), .out_word_last(out_ch.word_last)
);
